// ----- rtl/ufcc_pkg.sv -----
// ----------------------------------------------------------------------------
// ufcc_pkg
// Shared sizes, datapath operation codes and the control/status bundles
// of the union-find component counter.
// ----------------------------------------------------------------------------
package ufcc_pkg;

  localparam int MAX_NODES = 1024;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int NODE_W    = 11;
  localparam int CMP_W     = (CNT_W > NODE_W) ? CNT_W : NODE_W;

  localparam logic [NODE_W-1:0] NODE_CNT_RST = NODE_W'(1024);
  localparam logic [CNT_W-1:0]  CNT_RST      = CNT_W'((MAX_NODES < 1024) ? MAX_NODES : 1024);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_CLR_STEP,
    OP_FIND_INIT,
    OP_FIND_STEP,
    OP_COMP_INIT,
    OP_COMP_STEP,
    OP_SAVE_ROOT,
    OP_SZ_RD_A,
    OP_SZ_RD_B,
    OP_LINK
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   sel_b;   // walk works on node_b
  } dp_cmd_t;

  typedef struct packed {
    logic req_clr;
    logic bad;
    logic p_eq_r;      // parent read back equals current root guess
    logic cur_eq_r;
    logic roots_same;
    logic sweep_last;
  } dp_stat_t;

endpackage

// ----- rtl/ufcc_dp.sv -----
// ----------------------------------------------------------------------------
// ufcc_dp
// Datapath: parent and size memories, walk registers, set count and the
// node count register.
// ----------------------------------------------------------------------------
module ufcc_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ufcc_pkg::NODE_W-1:0] cfg_wdata_i,
  input  logic                      in_req_i,
  input  logic [ufcc_pkg::NODE_W-1:0] in_a_i,
  input  logic [ufcc_pkg::NODE_W-1:0] in_b_i,
  input  ufcc_pkg::dp_cmd_t         cmd_i,
  output ufcc_pkg::dp_stat_t        stat_o,
  output logic                      merged_o,
  output logic                      bad_o,
  output logic [ufcc_pkg::CNT_W-1:0] count_o
);
  import ufcc_pkg::*;

  logic [IDX_W-1:0]  parent_mem [MAX_NODES];
  logic [CNT_W-1:0]  size_mem   [MAX_NODES];

  logic [NODE_W-1:0] node_cnt_q;
  logic [CNT_W-1:0]  live;
  logic              req_q, bad_q, merged_q;
  logic [NODE_W-1:0] a_q, b_q;
  logic [CNT_W-1:0]  count_q, sza_q;
  logic [IDX_W-1:0]  idx_q, r_q, cur_q, ra_q, rb_q;
  logic [IDX_W-1:0]  pdat_q;
  logic [CNT_W-1:0]  sdat_q;

  logic [IDX_W-1:0]  slot;
  logic              in_bad;
  logic              grow_b;
  logic [IDX_W-1:0]  win, lose;

  logic              p_we;
  logic [IDX_W-1:0]  p_waddr, p_wdata, p_raddr;
  logic              s_we;
  logic [IDX_W-1:0]  s_waddr, s_raddr;
  logic [CNT_W-1:0]  s_wdata;

  // effective node count: zero acts as one, clamp at capacity
  always_comb begin
    if (node_cnt_q == '0) begin
      live = CNT_W'(1);
    end else if (CMP_W'(node_cnt_q) > CMP_W'(MAX_NODES)) begin
      live = CNT_W'(MAX_NODES);
    end else begin
      live = CNT_W'(node_cnt_q);
    end
  end

  assign in_bad = (in_a_i == '0) || (in_b_i == '0) ||
                  (CMP_W'(in_a_i) > CMP_W'(live)) || (CMP_W'(in_b_i) > CMP_W'(live));

  assign slot   = cmd_i.sel_b ? IDX_W'(b_q - NODE_W'(1)) : IDX_W'(a_q - NODE_W'(1));
  assign grow_b = sdat_q > sza_q;
  assign win    = grow_b ? rb_q : ra_q;
  assign lose   = grow_b ? ra_q : rb_q;

  // memory port control
  always_comb begin
    p_we    = 1'b0;
    p_waddr = idx_q;
    p_wdata = idx_q;
    p_raddr = '0;
    s_we    = 1'b0;
    s_waddr = idx_q;
    s_wdata = CNT_W'(1);
    s_raddr = '0;
    case (cmd_i.op)
      OP_CLR_STEP: begin
        p_we = 1'b1;
        s_we = 1'b1;
      end
      OP_FIND_INIT: p_raddr = slot;
      OP_FIND_STEP: p_raddr = pdat_q;
      OP_COMP_INIT: p_raddr = cur_q;
      OP_COMP_STEP: begin
        p_we    = 1'b1;
        p_waddr = cur_q;
        p_wdata = r_q;
        p_raddr = pdat_q;
      end
      OP_SZ_RD_A: s_raddr = ra_q;
      OP_SZ_RD_B: s_raddr = rb_q;
      OP_LINK: begin
        p_we    = 1'b1;
        p_waddr = lose;
        p_wdata = win;
        s_we    = 1'b1;
        s_waddr = win;
        s_wdata = sza_q + sdat_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    pdat_q <= parent_mem[p_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      size_mem[s_waddr] <= s_wdata;
    end
    sdat_q <= size_mem[s_raddr];
  end

  // control-type registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_cnt_q <= NODE_CNT_RST;
      count_q    <= CNT_RST;
      idx_q      <= '0;
      req_q      <= 1'b0;
      bad_q      <= 1'b0;
      merged_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_cnt_q <= cfg_wdata_i;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          req_q    <= in_req_i;
          bad_q    <= !in_req_i && in_bad;
          merged_q <= 1'b0;
          if (in_req_i) begin
            idx_q   <= '0;
            count_q <= live;
          end
        end
        OP_CLR_STEP: idx_q <= idx_q + IDX_W'(1);
        OP_LINK: begin
          merged_q <= 1'b1;
          if (count_q != '0) begin
            count_q <= count_q - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        a_q <= in_a_i;
        b_q <= in_b_i;
      end
      OP_FIND_INIT: begin
        r_q   <= slot;
        cur_q <= slot;
      end
      OP_FIND_STEP: r_q   <= pdat_q;
      OP_COMP_STEP: cur_q <= pdat_q;
      OP_SAVE_ROOT: begin
        if (cmd_i.sel_b) begin
          rb_q <= r_q;
        end else begin
          ra_q <= r_q;
        end
      end
      OP_SZ_RD_B: sza_q <= sdat_q;
      default: ;
    endcase
  end

  assign stat_o.req_clr    = req_q;
  assign stat_o.bad        = bad_q;
  assign stat_o.p_eq_r     = (pdat_q == r_q);
  assign stat_o.cur_eq_r   = (cur_q == r_q);
  assign stat_o.roots_same = (ra_q == rb_q);
  assign stat_o.sweep_last = (idx_q == IDX_W'(MAX_NODES - 1));

  assign merged_o = merged_q;
  assign bad_o    = bad_q;
  assign count_o  = count_q;

endmodule

// ----- rtl/ufcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ufcc_ctrl
// Sequencer: reset sweep, clear sweep, two root walks with compression,
// the size compare and link, and the hand-off of the result.
// ----------------------------------------------------------------------------
module ufcc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_free_i,
  output logic                emit_o,
  input  ufcc_pkg::dp_stat_t  stat_i,
  output ufcc_pkg::dp_cmd_t   cmd_o
);
  import ufcc_pkg::*;

  localparam logic [3:0] S_RST_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_DECODE    = 4'd2;
  localparam logic [3:0] S_CLR       = 4'd3;
  localparam logic [3:0] S_FIND_INIT = 4'd4;
  localparam logic [3:0] S_FIND      = 4'd5;
  localparam logic [3:0] S_COMP      = 4'd6;
  localparam logic [3:0] S_SAVE      = 4'd7;
  localparam logic [3:0] S_SZ_A      = 4'd8;
  localparam logic [3:0] S_SZ_B      = 4'd9;
  localparam logic [3:0] S_LINK      = 4'd10;
  localparam logic [3:0] S_DONE      = 4'd11;

  logic [3:0] state_q, state_d;
  logic       sel_q, sel_d;

  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    cmd_o.op   = OP_NOP;
    cmd_o.sel_b = sel_q;
    in_ready_o = 1'b0;
    emit_o     = 1'b0;
    case (state_q)
      S_RST_CLR: begin
        cmd_o.op = OP_CLR_STEP;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        sel_d = 1'b0;
        if (stat_i.req_clr) begin
          state_d = S_CLR;
        end else if (stat_i.bad) begin
          state_d = S_DONE;
        end else begin
          state_d = S_FIND_INIT;
        end
      end
      S_CLR: begin
        cmd_o.op = OP_CLR_STEP;
        if (stat_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_FIND_INIT: begin
        cmd_o.op = OP_FIND_INIT;
        state_d  = S_FIND;
      end
      S_FIND: begin
        if (stat_i.p_eq_r) begin
          if (stat_i.cur_eq_r) begin
            state_d = S_SAVE;
          end else begin
            cmd_o.op = OP_COMP_INIT;
            state_d  = S_COMP;
          end
        end else begin
          cmd_o.op = OP_FIND_STEP;
        end
      end
      S_COMP: begin
        cmd_o.op = OP_COMP_STEP;
        if (stat_i.p_eq_r) begin
          state_d = S_SAVE;
        end
      end
      S_SAVE: begin
        cmd_o.op = OP_SAVE_ROOT;
        if (sel_q) begin
          state_d = S_SZ_A;
        end else begin
          sel_d   = 1'b1;
          state_d = S_FIND_INIT;
        end
      end
      S_SZ_A: begin
        if (stat_i.roots_same) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_SZ_RD_A;
          state_d  = S_SZ_B;
        end
      end
      S_SZ_B: begin
        cmd_o.op = OP_SZ_RD_B;
        state_d  = S_LINK;
      end
      S_LINK: begin
        cmd_o.op = OP_LINK;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RST_CLR;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule

// ----- rtl/union_find_component_counter.sv -----
// ----------------------------------------------------------------------------
// union_find_component_counter
// Disjoint-set engine (union by size, full path compression) that counts
// the connected components over nodes 1..node_count.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake                    | contents
//  ----------+-----+------------------------------+------------------------------
//  s_axis    | in  | tvalid/tready                | tuser: req_type,
//            |     |                              | tdata: node_a, node_b
//  m_axis    | out | tvalid/tready                | tdata: components,
//            |     |                              | tuser: merged, bad_node
//  cfg       | in  | cfg_we_i (no wait)           | node_count
//
//  Reset runs a sweep over all 1024 memory rows with s_axis_tready low; config
//  writes are taken during it. A clear item is accepted and decoded, runs the
//  same sweep, then hands off its result. A join walks both ends to their roots
//  and compresses both paths, one parent-memory access per step of each walk;
//  the size reads and link are skipped when both ends already share a root.
//  A bad endpoint goes from decode straight to the result. One item is in
//  work at a time; the result register lets the next item enter while
//  m_axis stalls.
//
module union_find_component_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,    // node_count
  // requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [10:0] node_a, [21:11] node_b, [23:22] zero
  input  logic        s_axis_tuser,   // [0] req_type
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [10:0] components, [15:11] zero
  output logic [1:0]  m_axis_tuser    // [0] merged, [1] bad_node
);
  import ufcc_pkg::*;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic              emit;
  logic              out_free;
  logic              merged, bad;
  logic [CNT_W-1:0]  count;

  logic              m_valid_q;
  logic [15:0]       m_data_q;
  logic [1:0]        m_user_q;

  // result slot can take a new item when empty or being drained
  assign out_free = !m_valid_q || m_axis_tready;

  ufcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .emit_o     (emit),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ufcc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (s_axis_tuser),
    .in_a_i      (s_axis_tdata[10:0]),
    .in_b_i      (s_axis_tdata[21:11]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .merged_o    (merged),
    .bad_o       (bad),
    .count_o     (count)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= {5'b0, NODE_W'(count)};
      m_user_q <= {bad, merged};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the union-find component counter. A directed
// table covers bad endpoints, self and repeat joins, clears, node-count
// limits and the count floor at zero. It is followed by randomized phases
// over several node counts. Each result is checked against a written-out
// expected value or an in-bench disjoint-set predictor.
// ----------------------------------------------------------------------------
module testbench;
  import ufcc_pkg::*;

  // request codes carried on s_axis_tuser
  localparam logic REQ_JOIN  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // cycles without any handshake before the run is declared hung; this
  // outlasts a clear sweep by a wide margin, leaving room for output stalls
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_TAIL  = 64;
  localparam int PHASE_ITEMS = 130;

  typedef struct packed {
    logic              merged;
    logic [NODE_W-1:0] components;
    logic              bad_node;
  } uf_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // one directed step: either an item or a node_count write (value in a)
  typedef struct packed {
    row_kind_e         kind;
    logic              req;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    bit                typed;   // res below is the expected result
    uf_result_t        res;
  } row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [10:0]       cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata  = '0;
  logic              s_axis_tuser  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;

  // predictor state: forest, set sizes, component count, node_count register
  logic [IDX_W-1:0]  parent_q [MAX_NODES];
  logic [NODE_W-1:0] size_q   [MAX_NODES];
  logic [NODE_W-1:0] count_q;
  logic [NODE_W-1:0] node_cnt_q;

  uf_result_t        predicted_results [$];
  int unsigned       err_count  = 0;
  int unsigned       idle_ticks = 0;
  bit                no_gaps    = 1'b0;   // both sides run flat out

  union_find_component_counter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // node_count of 0 behaves as 1, anything past the array as the array size
  function automatic logic [NODE_W-1:0] live_nodes();
    if (node_cnt_q == '0) return NODE_W'(1);
    if (node_cnt_q > NODE_W'(MAX_NODES)) return NODE_W'(MAX_NODES);
    return node_cnt_q;
  endfunction

  function automatic void init_sets();
    for (int i = 0; i < MAX_NODES; i++) begin
      parent_q[i] = IDX_W'(i);
      size_q[i]   = NODE_W'(1);
    end
    count_q = live_nodes();
  endfunction

  // walk to the root, then point every node on the path straight at it
  function automatic logic [IDX_W-1:0] find_root(logic [IDX_W-1:0] slot);
    logic [IDX_W-1:0] root;
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] nxt;
    root = slot;
    while (parent_q[root] != root) root = parent_q[root];
    cur = slot;
    while (cur != root) begin
      nxt           = parent_q[cur];
      parent_q[cur] = root;
      cur           = nxt;
    end
    return root;
  endfunction

  function automatic uf_result_t apply_request(logic req, logic [NODE_W-1:0] a,
                                               logic [NODE_W-1:0] b);
    uf_result_t       res;
    logic [NODE_W-1:0] lim;
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] rb;
    logic [IDX_W-1:0] tmp;
    res = '0;
    lim = live_nodes();
    if (req == REQ_CLEAR) begin
      init_sets();
    end else if (a == '0 || b == '0 || a > lim || b > lim) begin
      res.bad_node = 1'b1;
    end else begin
      ra = find_root(IDX_W'(a - 1'b1));
      rb = find_root(IDX_W'(b - 1'b1));
      if (ra != rb) begin
        // smaller set goes under the larger; a tie keeps node_a's root on top
        if (size_q[rb] > size_q[ra]) begin
          tmp = ra;
          ra  = rb;
          rb  = tmp;
        end
        parent_q[rb] = ra;
        size_q[ra]   = size_q[ra] + size_q[rb];
        if (count_q != '0) count_q = count_q - 1'b1;   // floor at zero
        res.merged = 1'b1;
      end
    end
    res.components = count_q;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // present one item with a random lead-in gap, wait for the handshake,
  // then record what should come back for it
  task automatic push_item(input logic req, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b, input bit typed,
                           input uf_result_t typed_res);
    uf_result_t res;
    while (!no_gaps && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {2'b00, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = apply_request(req, a, b);
    predicted_results.push_back(typed ? typed_res : res);
  endtask

  // every item returns a result, so an empty queue means the block is idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_node_count(input logic [NODE_W-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    node_cnt_q   = value;
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  // Expected values are written out where they are obvious; the tie-size
  // merge row goes through the predictor.
  row_t dir_rows [0:23] = '{
    // bad endpoints right after reset (node_count 1024, 1024 sets)
    '{ROW_ITEM, REQ_JOIN,  11'd0,    11'd5,    1'b1, '{1'b0, 11'd1024, 1'b1}},
    '{ROW_ITEM, REQ_JOIN,  11'd5,    11'd0,    1'b1, '{1'b0, 11'd1024, 1'b1}},
    '{ROW_ITEM, REQ_JOIN,  11'd1025, 11'd1,    1'b1, '{1'b0, 11'd1024, 1'b1}},
    '{ROW_ITEM, REQ_JOIN,  11'd2047, 11'd2047, 1'b1, '{1'b0, 11'd1024, 1'b1}},
    // first and last node, repeat join, self join
    '{ROW_ITEM, REQ_JOIN,  11'd1,    11'd1024, 1'b1, '{1'b1, 11'd1023, 1'b0}},
    '{ROW_ITEM, REQ_JOIN,  11'd1024, 11'd1,    1'b1, '{1'b0, 11'd1023, 1'b0}},
    '{ROW_ITEM, REQ_JOIN,  11'd7,    11'd7,    1'b1, '{1'b0, 11'd1023, 1'b0}},
    '{ROW_ITEM, REQ_JOIN,  11'd2,    11'd3,    1'b1, '{1'b1, 11'd1022, 1'b0}},
    '{ROW_ITEM, REQ_JOIN,  11'd3,    11'd1,    1'b0, '{1'b0, 11'd0,    1'b0}},
    // clear ignores its endpoints
    '{ROW_ITEM, REQ_CLEAR, 11'd2047, 11'd2047, 1'b1, '{1'b0, 11'd1024, 1'b0}},
    // node_count 0 acts as 1; the count keeps its value until a clear
    '{ROW_CFG,  REQ_JOIN,  11'd0,    11'd0,    1'b0, '{1'b0, 11'd0,    1'b0}},
    '{ROW_ITEM, REQ_JOIN,  11'd1,    11'd1,    1'b1, '{1'b0, 11'd1024, 1'b0}},
    '{ROW_ITEM, REQ_JOIN,  11'd1,    11'd2,    1'b1, '{1'b0, 11'd1024, 1'b1}},
    '{ROW_ITEM, REQ_CLEAR, 11'd0,    11'd0,    1'b1, '{1'b0, 11'd1,    1'b0}},
    // raise to max without a clear: count drops to zero and stays there
    '{ROW_CFG,  REQ_JOIN,  11'd2047, 11'd0,    1'b0, '{1'b0, 11'd0,    1'b0}},
    '{ROW_ITEM, REQ_JOIN,  11'd1,    11'd1024, 1'b1, '{1'b1, 11'd0,    1'b0}},
    '{ROW_ITEM, REQ_JOIN,  11'd2,    11'd3,    1'b1, '{1'b1, 11'd0,    1'b0}},
    // four nodes joined down to one set
    '{ROW_CFG,  REQ_JOIN,  11'd4,    11'd0,    1'b0, '{1'b0, 11'd0,    1'b0}},
    '{ROW_ITEM, REQ_CLEAR, 11'd1,    11'd4,    1'b1, '{1'b0, 11'd4,    1'b0}},
    '{ROW_ITEM, REQ_JOIN,  11'd1,    11'd4,    1'b1, '{1'b1, 11'd3,    1'b0}},
    '{ROW_ITEM, REQ_JOIN,  11'd5,    11'd1,    1'b1, '{1'b0, 11'd3,    1'b1}},
    '{ROW_ITEM, REQ_JOIN,  11'd2,    11'd4,    1'b1, '{1'b1, 11'd2,    1'b0}},
    '{ROW_ITEM, REQ_JOIN,  11'd3,    11'd2,    1'b1, '{1'b1, 11'd1,    1'b0}},
    '{ROW_ITEM, REQ_JOIN,  11'd1,    11'd3,    1'b1, '{1'b0, 11'd1,    1'b0}}
  };

  // random phases: node_count written, then an optional clear; skipping the
  // clear after a small count leaves the count low against many nodes
  int unsigned phase_cnt [8] = '{16, 2, 1024, 64, 1, 300, 2047, 128};
  bit          phase_clr [8] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [NODE_W-1:0] lim;
    int unsigned       pick;
    node_cnt_q = NODE_W'(1024);
    init_sets();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_node_count(dir_rows[i].a);
      end else begin
        push_item(dir_rows[i].req, dir_rows[i].a, dir_rows[i].b,
                  dir_rows[i].typed, dir_rows[i].res);
      end
    end

    for (int p = 0; p < 8; p++) begin
      write_node_count(NODE_W'(phase_cnt[p]));
      no_gaps = (p == 3);
      if (phase_clr[p]) push_item(REQ_CLEAR, NODE_W'($urandom), NODE_W'($urandom), 1'b0, '0);
      lim = live_nodes();
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          push_item(REQ_CLEAR, NODE_W'($urandom), NODE_W'($urandom), 1'b0, '0);
          lim = live_nodes();
        end else if (pick < 10) begin
          // noise: full-range endpoints, mostly out of range
          push_item(REQ_JOIN, NODE_W'($urandom_range(2047)), NODE_W'($urandom_range(2047)),
                    1'b0, '0);
        end else begin
          push_item(REQ_JOIN, NODE_W'($urandom_range(lim, 1)), NODE_W'($urandom_range(lim, 1)),
                    1'b0, '0);
        end
      end
    end
    no_gaps = 1'b0;

    settle();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: random backpressure and result checking
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    m_axis_tready <= no_gaps || ($urandom_range(99) >= 37);
  end

  always @(posedge clk_i) begin
    uf_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (predicted_results.size() == 0) begin
        $error("unexpected result: components %0d", m_axis_tdata[10:0]);
        err_count++;
      end else begin
        want = predicted_results.pop_front();
        if (m_axis_tuser[0] !== want.merged) begin
          $error("merged: expected %0d, got %0d", want.merged, m_axis_tuser[0]);
          err_count++;
        end
        if (m_axis_tdata[10:0] !== want.components) begin
          $error("components: expected %0d, got %0d", want.components, m_axis_tdata[10:0]);
          err_count++;
        end
        if (m_axis_tuser[1] !== want.bad_node) begin
          $error("bad_node: expected %0d, got %0d", want.bad_node, m_axis_tuser[1]);
          err_count++;
        end
      end
    end
  end

  // hang detector: any handshake on either side restarts the count
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_ticks <= 0;
    end else if (idle_ticks >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_ticks <= idle_ticks + 1;
    end
  end

endmodule
